@@ rtl/core/linear_interp_upscaler_defines.svh @@
// Assertion macros for the linear interpolation upscaler.
// Used by modules that include this header; needs clk_i and rst_ni in scope.
`ifndef LINEAR_INTERP_UPSCALER_DEFINES_SVH
`define LINEAR_INTERP_UPSCALER_DEFINES_SVH

// same-cycle implication
`define LIU_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define LIU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/core/liu_pkg.sv @@
// Shared types, constants and the interpolation step for the upscaler.
// No dependencies.
package liu_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_FACTOR_DEF = 4;
  localparam int MAX_HEIGHT     = 1024;
  localparam int PIX_W          = 8;
  localparam int ROW_W          = 10;
  localparam int FACTOR_W       = 3;
  localparam int DIM_W          = 11;
  localparam int COORD_W        = 12;
  localparam int CFG_IDX_W      = 2;
  localparam int SUM_W          = 10;
  localparam int RECIP3         = 683;
  localparam int RECIP3_SH      = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FACTOR = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_HORIZ,
    ST_VERT
  } state_e;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic horiz;
    logic vert_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_blk;
    logic last_step;
    logic out_free;
  } ctrl_sts_t;

  // floor((a*(f-k) + b*k) / f) for f in 1..4
  function automatic logic [PIX_W-1:0] lerp(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b,
                                             input logic [FACTOR_W-1:0] k,
                                             input logic [FACTOR_W-1:0] f);
    logic [SUM_W-1:0]   sum;
    logic [2*SUM_W-1:0] prod;
    logic [PIX_W-1:0]   res;
    logic [FACTOR_W-1:0] fk;
    fk   = f - k;
    sum  = SUM_W'(SUM_W'(a) * SUM_W'(fk)) + SUM_W'(SUM_W'(b) * SUM_W'(k));
    prod = (2*SUM_W)'(sum) * (2*SUM_W)'(RECIP3);
    unique case (f)
      3'd2:    res = sum[PIX_W:1];
      3'd3:    res = prod[RECIP3_SH+PIX_W-1:RECIP3_SH];
      3'd4:    res = sum[PIX_W+1:2];
      default: res = sum[PIX_W-1:0];
    endcase
    return res;
  endfunction

endpackage

@@ rtl/core/liu_ctrl.sv @@
// Sequencing state machine of the upscaler.
// Depends on liu_pkg; drives liu_dpath through ctrl_cmd_t.
module liu_ctrl import liu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_FETCH;
      end
      ST_FETCH: begin
        state_d = sts_i.has_blk ? ST_HORIZ : ST_IDLE;
      end
      ST_HORIZ: begin
        state_d = ST_VERT;
      end
      ST_VERT: begin
        if (sts_i.out_free) state_d = sts_i.last_step ? ST_IDLE : ST_HORIZ;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    cmd_o.accept    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.fetch     = (state_q == ST_FETCH);
    cmd_o.horiz     = (state_q == ST_HORIZ);
    cmd_o.vert_load = (state_q == ST_VERT) && sts_i.out_free;
  end

endmodule

@@ rtl/core/liu_dpath.sv @@
// Datapath of the upscaler: settings, line buffer, counters, interpolator, output beat.
// Depends on liu_pkg and linear_interp_upscaler_defines.svh; steered by liu_ctrl.
`include "linear_interp_upscaler_defines.svh"
module liu_dpath import liu_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_FACTOR = MAX_FACTOR_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  logic [PIX_W-1:0]     pixel_in_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [PIX_W-1:0]     pixel_out_o,
  output logic [COORD_W-1:0]   out_col_o,
  output logic [COORD_W-1:0]   out_row_o,
  output logic                 last_of_run_o,
  output logic                 frame_done_o,
  input  ctrl_cmd_t            cmd_i,
  output ctrl_sts_t            sts_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int KW  = $clog2(MAX_FACTOR);
  localparam int WCW = DIM_W + 2;
  localparam int PW  = COORD_W + FACTOR_W;

  logic [FACTOR_W-1:0] factor_q;
  logic [DIM_W-1:0]    width_q, height_q;

  logic [PIX_W-1:0] row_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_q, pix_q, left_q, ul_q;
  logic [CW-1:0]    col_cnt_q;
  logic [ROW_W-1:0] row_cnt_q;

  logic [PIX_W-1:0]    e_ul_q, e_up_q, e_left_q, e_p_q;
  logic [CW-1:0]       e_c_q;
  logic [ROW_W-1:0]    e_r_q;
  logic [FACTOR_W-1:0] e_f_q;
  logic                e_end_q;
  logic [3:0]          mask_q;
  logic [KW-1:0]       kx_q, ky_q;

  logic [PIX_W-1:0]   top_q, bot_q;
  logic [COORD_W-1:0] hcol_q, hrow_q;
  logic               hlast_q, hdone_q;

  logic               out_valid_q;
  logic [PIX_W-1:0]   pix_out_q;
  logic [COORD_W-1:0] col_out_q, row_out_q;
  logic               last_out_q, done_out_q;

  logic [FACTOR_W-1:0] f_eff;
  logic [WCW-1:0]      w_eff;
  logic [DIM_W-1:0]    h_eff;
  logic                last_col, last_row;
  logic [3:0]          mask_new, low_bit;
  logic [1:0]          sel;
  logic [PIX_W-1:0]    p00, p01, p10, p11;
  logic [ROW_W-1:0]    brow;
  logic [CW-1:0]       bcol;
  logic [PW-1:0]       row_prod, col_prod;
  logic [FACTOR_W-1:0] kx_ext, ky_ext, f_m1;
  logic                kx_end, ky_end, last_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FACTOR_W'(MAX_FACTOR_DEF);
      width_q  <= DIM_W'(MAX_WIDTH_DEF);
      height_q <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_FACTOR: factor_q <= cfg_data_i[FACTOR_W-1:0];
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (factor_q == '0) f_eff = FACTOR_W'(1);
    else if (factor_q > FACTOR_W'(MAX_FACTOR)) f_eff = FACTOR_W'(MAX_FACTOR);
    else f_eff = factor_q;
    if (width_q == '0) w_eff = WCW'(1);
    else if (WCW'(width_q) > WCW'(MAX_WIDTH)) w_eff = WCW'(MAX_WIDTH);
    else w_eff = WCW'(width_q);
    if (height_q == '0) h_eff = DIM_W'(1);
    else if (height_q > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
    else h_eff = height_q;
    last_col = WCW'(col_cnt_q) >= (w_eff - WCW'(1));
    last_row = DIM_W'(row_cnt_q) >= (h_eff - DIM_W'(1));
    mask_new[0] = (row_cnt_q != '0) && (col_cnt_q != '0);
    mask_new[1] = (row_cnt_q != '0) && last_col;
    mask_new[2] = last_row && (col_cnt_q != '0);
    mask_new[3] = last_row && last_col;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q  <= row_mem[col_cnt_q];
      pix_q <= pixel_in_i;
    end
    if (cmd_i.fetch) begin
      row_mem[col_cnt_q] <= pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q    <= '0;
      ul_q      <= '0;
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      mask_q    <= '0;
      kx_q      <= '0;
      ky_q      <= '0;
    end else if (cmd_i.fetch) begin
      left_q <= pix_q;
      ul_q   <= rd_q;
      mask_q <= mask_new;
      kx_q   <= '0;
      ky_q   <= '0;
      if (last_col) begin
        col_cnt_q <= '0;
        row_cnt_q <= last_row ? '0 : row_cnt_q + ROW_W'(1);
      end else begin
        col_cnt_q <= col_cnt_q + CW'(1);
      end
    end else if (cmd_i.vert_load) begin
      if (kx_end) begin
        kx_q <= '0;
        if (ky_end) begin
          ky_q   <= '0;
          mask_q <= mask_q & ~low_bit;
        end else begin
          ky_q <= ky_q + KW'(1);
        end
      end else begin
        kx_q <= kx_q + KW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      e_ul_q   <= ul_q;
      e_up_q   <= rd_q;
      e_left_q <= left_q;
      e_p_q    <= pix_q;
      e_c_q    <= col_cnt_q;
      e_r_q    <= row_cnt_q;
      e_f_q    <= f_eff;
      e_end_q  <= last_row && last_col;
    end
  end

  always_comb begin
    low_bit   = mask_q & (~mask_q + 4'd1);
    priority if (mask_q[0]) sel = 2'd0;
    else if (mask_q[1])     sel = 2'd1;
    else if (mask_q[2])     sel = 2'd2;
    else                    sel = 2'd3;
    unique case (sel)
      2'd0: begin p00 = e_ul_q;   p01 = e_up_q; p10 = e_left_q; p11 = e_p_q; end
      2'd1: begin p00 = e_up_q;   p01 = e_up_q; p10 = e_p_q;    p11 = e_p_q; end
      2'd2: begin p00 = e_left_q; p01 = e_p_q;  p10 = e_left_q; p11 = e_p_q; end
      default: begin p00 = e_p_q; p01 = e_p_q;  p10 = e_p_q;    p11 = e_p_q; end
    endcase
    brow      = sel[1] ? e_r_q : e_r_q - ROW_W'(1);
    bcol      = sel[0] ? e_c_q : e_c_q - CW'(1);
    row_prod  = PW'(brow) * PW'(e_f_q);
    col_prod  = PW'(bcol) * PW'(e_f_q);
    kx_ext    = FACTOR_W'(kx_q);
    ky_ext    = FACTOR_W'(ky_q);
    f_m1      = e_f_q - FACTOR_W'(1);
    kx_end    = (kx_ext == f_m1);
    ky_end    = (ky_ext == f_m1);
    last_step = kx_end && ky_end && ((mask_q & (mask_q - 4'd1)) == 4'd0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.horiz) begin
      top_q   <= lerp(p00, p01, kx_ext, e_f_q);
      bot_q   <= lerp(p10, p11, kx_ext, e_f_q);
      hrow_q  <= row_prod[COORD_W-1:0] + COORD_W'(ky_q);
      hcol_q  <= col_prod[COORD_W-1:0] + COORD_W'(kx_q);
      hlast_q <= last_step;
      hdone_q <= last_step && e_end_q;
    end
    if (cmd_i.vert_load) begin
      pix_out_q  <= lerp(top_q, bot_q, ky_ext, e_f_q);
      row_out_q  <= hrow_q;
      col_out_q  <= hcol_q;
      last_out_q <= hlast_q;
      done_out_q <= hdone_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.vert_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.has_blk   = (mask_new != 4'd0);
  assign sts_o.last_step = last_step;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign pixel_out_o   = pix_out_q;
  assign out_col_o     = col_out_q;
  assign out_row_o     = row_out_q;
  assign last_of_run_o = last_out_q;
  assign frame_done_o  = done_out_q;

  `LIU_ASSERT_NOW(a_no_overwrite, cmd_i.vert_load, !out_valid_q || out_ready_i, "beat overwritten")
  `LIU_ASSERT_NOW(a_load_has_blk, cmd_i.vert_load, mask_q != 4'd0, "load with no block left")
  `LIU_ASSERT_NEXT(a_col_wrap, cmd_i.fetch && last_col, col_cnt_q == '0, "column count not wrapped")
  `LIU_ASSERT_NEXT(a_run_end, cmd_i.vert_load && last_step, mask_q == 4'd0, "blocks left after run")

endmodule

@@ rtl/core/linear_interp_upscaler.sv @@
// Top level of the integer-factor bilinear upscaler.
// Depends on liu_pkg, liu_ctrl and liu_dpath.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------------
//   in      | sink      | in_valid_i/in_ready_o  | pixel_in_i
//   out     | source    | out_valid_o/out_ready_i| pixel_out_o out_col_o out_row_o
//           |           |                        | last_of_run_o frame_done_o
//   cfg     | sink      | cfg_valid_i/cfg_ready_o| cfg_index_i cfg_data_i
//
// An item that completes no block makes no beat; else it makes n beats (n up to 4*f*f),
// each through the interpolator's horizontal step, then its vertical step.
// Line buffer has no clearing pass after reset; cfg is always ready.
// A stalled output beat holds the vertical step; the next item is taken while the last
// beat of the previous one waits.
module linear_interp_upscaler import liu_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_FACTOR = MAX_FACTOR_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PIX_W-1:0]     pixel_in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PIX_W-1:0]     pixel_out_o,
  output logic [COORD_W-1:0]   out_col_o,
  output logic [COORD_W-1:0]   out_row_o,
  output logic                 last_of_run_o,
  output logic                 frame_done_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  liu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  liu_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_in_i    (pixel_in_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .pixel_out_o   (pixel_out_o),
    .out_col_o     (out_col_o),
    .out_row_o     (out_row_o),
    .last_of_run_o (last_of_run_o),
    .frame_done_o  (frame_done_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

@@ dv/linear_interp_upscaler_test.sv @@
// Testbench for linear_interp_upscaler: drives frames, some only in part, under several scale
// and size settings and checks every output beat against a built-in bilinear predictor.
// Depends on liu_pkg and the upscaler RTL.
`timescale 1ns / 1ps

module linear_interp_upscaler_test;
  import liu_pkg::*;

  localparam int LB_AW = $clog2(MAX_WIDTH_DEF);

  typedef struct {
    logic [PIX_W-1:0]   pix;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
    logic               done;
  } up_beat_t;

  class upscale_scoreboard;
    logic [FACTOR_W-1:0] factor_reg = 3'd4;
    logic [DIM_W-1:0]    width_reg  = 11'd1024;
    logic [DIM_W-1:0]    height_reg = 11'd1024;
    logic [PIX_W-1:0]    line_buf[MAX_WIDTH_DEF];
    int unsigned         left_pix, upleft_pix, col_cnt, row_cnt;
    up_beat_t            upscaled_q[$];
    int                  errors, beats, pixels;

    function void write_reg(cfg_idx_e idx, logic [DIM_W-1:0] val);
      case (idx)
        REG_FACTOR: factor_reg = val[FACTOR_W-1:0];
        REG_WIDTH:  width_reg  = val;
        REG_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    function int unsigned blend(int unsigned a, int unsigned b, int unsigned k,
                                int unsigned f);
      return (a * (f - k) + b * k) / f;
    endfunction

    function void push_block(int unsigned p00, int unsigned p01, int unsigned p10,
                             int unsigned p11, int unsigned brow, int unsigned bcol,
                             int unsigned f);
      up_beat_t b;
      for (int unsigned ky = 0; ky < f; ky++) begin
        for (int unsigned kx = 0; kx < f; kx++) begin
          b.pix  = PIX_W'(blend(blend(p00, p01, kx, f), blend(p10, p11, kx, f), ky, f));
          b.col  = COORD_W'(bcol * f + kx);
          b.row  = COORD_W'(brow * f + ky);
          b.last = 1'b0;
          b.done = 1'b0;
          upscaled_q.push_back(b);
        end
      end
    endfunction

    function void note_pixel(logic [PIX_W-1:0] p);
      int unsigned f, w, h, upper, before_n;
      bit end_col, end_row;
      f = factor_reg;
      w = width_reg;
      h = height_reg;
      if (f < 1) f = 1;
      if (f > MAX_FACTOR_DEF) f = MAX_FACTOR_DEF;
      if (w < 1) w = 1;
      if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
      if (h < 1) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      end_col  = col_cnt >= w - 1;
      end_row  = row_cnt >= h - 1;
      upper    = (col_cnt < MAX_WIDTH_DEF) ? line_buf[LB_AW'(col_cnt)] : 0;
      before_n = upscaled_q.size();
      pixels++;
      if (row_cnt >= 1 && col_cnt >= 1)
        push_block(upleft_pix, upper, left_pix, p, row_cnt - 1, col_cnt - 1, f);
      if (row_cnt >= 1 && end_col)
        push_block(upper, upper, p, p, row_cnt - 1, col_cnt, f);
      if (end_row && col_cnt >= 1)
        push_block(left_pix, p, left_pix, p, row_cnt, col_cnt - 1, f);
      if (end_row && end_col)
        push_block(p, p, p, p, row_cnt, col_cnt, f);
      if (upscaled_q.size() > before_n) begin
        upscaled_q[$].last = 1'b1;
        upscaled_q[$].done = end_row && end_col;
      end
      upleft_pix = upper;
      if (col_cnt < MAX_WIDTH_DEF) line_buf[LB_AW'(col_cnt)] = p;
      left_pix = p;
      if (end_col) begin
        col_cnt = 0;
        row_cnt = end_row ? 0 : row_cnt + 1;
      end else begin
        col_cnt++;
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_beat(up_beat_t got);
      up_beat_t exp;
      beats++;
      if (upscaled_q.size() == 0) begin
        report($sformatf("unexpected beat pix=%0d col=%0d row=%0d",
                         got.pix, got.col, got.row));
        return;
      end
      exp = upscaled_q.pop_front();
      if (got.pix !== exp.pix || got.col !== exp.col || got.row !== exp.row ||
          got.last !== exp.last || got.done !== exp.done)
        report($sformatf("got pix=%0d col=%0d row=%0d last=%b done=%b, want %0d %0d %0d %b %b",
                         got.pix, got.col, got.row, got.last, got.done,
                         exp.pix, exp.col, exp.row, exp.last, exp.done));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DIM_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [PIX_W-1:0]     pixel_in_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [PIX_W-1:0]     pixel_out_o;
  logic [COORD_W-1:0]   out_col_o;
  logic [COORD_W-1:0]   out_row_o;
  logic                 last_of_run_o;
  logic                 frame_done_o;

  upscale_scoreboard sb = new();
  bit steady;
  int ready_hold;
  int idle_cycles;
  int settings;

  linear_interp_upscaler dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_hold  <= 0;
    end else if (steady) begin
      out_ready_i <= 1'b1;
    end else if (ready_hold == 0) begin
      out_ready_i <= ($urandom_range(0, 3) != 0);
      ready_hold  <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 3);
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  always @(posedge clk_i) begin
    up_beat_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.pix  = pixel_out_o;
        got.col  = out_col_o;
        got.row  = out_row_o;
        got.last = last_of_run_o;
        got.done = frame_done_o;
        sb.check_beat(got);
      end
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("watchdog expired, %0d beats outstanding", sb.upscaled_q.size());
        $display("[linear_interp_upscaler] ERROR");
        $finish;
      end
    end
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task send_pixel(logic [PIX_W-1:0] p);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_pixel(p);
  endtask

  task drain();
    in_valid_i <= 1'b0;
    while (sb.upscaled_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task cfg_write(cfg_idx_e idx, logic [DIM_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task setup(logic [DIM_W-1:0] f, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    drain();
    cfg_write(REG_FACTOR, f);
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  function logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task send_frame(int n);
    for (int i = 0; i < n; i++) send_pixel(rand_pixel());
  endtask

  initial begin
    int w, h, rand_items;
    bit paused;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    setup(11'd0, 11'd1, 11'd1);
    send_pixel(8'hff);
    setup(11'd4, 11'd2, 11'd2);
    send_pixel(8'h00);
    send_pixel(8'hff);
    send_pixel(8'hff);
    send_pixel(8'h00);
    setup(11'd3, 11'd3, 11'd2);
    send_pixel(8'hff);
    send_pixel(8'h00);
    send_pixel(8'h80);
    send_pixel(8'h07);
    send_pixel(8'hff);
    send_pixel(8'h00);
    setup(11'd2, 11'd1, 11'd3);
    send_frame(3);
    setup(11'd7, 11'd3, 11'd1);
    send_frame(3);
    drain();
    cfg_write(cfg_idx_e'(2'd3), 11'h555);
    cfg_valid_i <= 1'b0;

    // hold width, shrink height partway through a frame
    setup(11'd2, 11'd3, 11'd4);
    send_frame(5);
    drain();
    cfg_write(REG_HEIGHT, 11'd2);
    cfg_valid_i <= 1'b0;
    send_pixel(8'h5a);

    steady = 1'b1;
    setup(11'd1, 11'd2047, 11'd0);
    send_frame(24);
    setup(11'd1, 11'd0, 11'd1024);
    send_frame(12);
    steady = 1'b0;

    rand_items = 0;
    paused = 1'b0;
    while (rand_items < 170) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 5);
      setup(DIM_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 7)
                                               : $urandom_range(1, 4)),
            DIM_W'(w), DIM_W'(h));
      steady = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < w * h; i++) begin
        if (!paused && rand_items > 100 && i == w * h / 2) begin
          in_valid_i <= 1'b0;
          while (sb.upscaled_q.size() != 0) @(posedge clk_i);
          paused = 1'b1;
        end
        send_pixel(rand_pixel());
        rand_items++;
      end
      steady = 1'b0;
    end

    drain();
    repeat (40) @(posedge clk_i);
    $display("sent %0d pixels across %0d settings, checked %0d output beats",
             sb.pixels, settings, sb.beats);
    if (sb.errors == 0 && sb.upscaled_q.size() == 0) begin
      $display("[linear_interp_upscaler] OK");
    end else begin
      $display("[linear_interp_upscaler] ERROR");
    end
    $finish;
  end

endmodule
